### design/assert_macros.svh
// Assertion macros used by the alarm table top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property check that is switched off while reset is asserted.
`define ATMT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property check that also holds during reset.
`define ATMT_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ATMT_ASSERT(name, clk, rst_n, prop, msg)
`define ATMT_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### design/atmt_pkg.sv
// Types and constants shared by the alarm time match table design.
`default_nettype none

package atmt_pkg;

	// Operation codes of a request.
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_SET_EN = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	// Limits of a valid time of day.
	localparam logic [4:0] HOUR_LIMIT   = 5'd24;
	localparam logic [5:0] MINUTE_LIMIT = 6'd60;
	localparam logic [5:0] SECOND_ZERO  = 6'd0;

	// Status codes.
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Request payload.
	typedef struct packed {
		logic [2:0] op;
		logic [4:0] time_hour;
		logic [5:0] time_minute;
		logic [5:0] time_second;
		logic [4:0] entry_hour;
		logic [5:0] entry_minute;
		logic       play_kind;
		logic       enable_value;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic status;
		logic fired;
		logic fired_is_play;
		logic is_active;
	} rsp_t;

	// One stored alarm.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       enabled;
		logic       play;
	} entry_t;

	// Update commands from the sequencer to the slot store.
	typedef struct packed {
		logic wr_entry;
		logic set_valid;
		logic clr_valid;
		logic clr_all;
	} slot_cmd_t;

endpackage

`default_nettype wire

### design/atmt_chan_if.sv
// Valid/ready channel interface carrying one request or response payload.
`default_nettype none

interface atmt_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/atmt_slot_store.sv
// Alarm slot store: valid flags in flip-flops, alarm contents in a memory with one write port and one read port.
`default_nettype none

module atmt_slot_store #(
	parameter int SLOTS = 16,
	parameter int IW    = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [IW-1:0]       rd_addr,
	output      logic                rd_valid,
	output      atmt_pkg::entry_t    rd_data,
	input  wire atmt_pkg::slot_cmd_t cmd,
	input  wire logic [IW-1:0]       wr_addr,
	input  wire atmt_pkg::entry_t    wr_data
);
	import atmt_pkg::*;

	logic [SLOTS-1:0] valid_q;
	entry_t           mem_q [SLOTS];
	logic             rd_valid_q;
	entry_t           rd_data_q;

	// Valid flags are cleared by reset and by a clear request, and set or cleared per slot by update commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clr_all) begin
			valid_q <= '0;
		end else if (cmd.set_valid) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (cmd.clr_valid) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	// Contents memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q  <= mem_q[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_data  = rd_data_q;

endmodule

`default_nettype wire

### design/alarm_time_match_table_unit.sv
// Top level of the alarm time match table: request sequencer, slot scan and response register.
// Each request is answered by exactly one response. A request that needs a key lookup (tick at
// second zero, add of a valid time, remove, set enable, query) walks every slot through the
// store's single read port, one slot per cycle, before its update is applied and its response
// posted; the next request is accepted only after that response is posted. A clear, a tick at
// a non-zero second, an add of an invalid time or an unused operation skips the walk and goes
// straight to the update and response. One request is in progress at a time. The response sits
// in an output register, so the sequencer only waits for the response side when the previous
// response has not yet been taken. No clearing pass is needed after reset: the valid flags reset
// at once.
`default_nettype none

`include "assert_macros.svh"

module alarm_time_match_table_unit #(
	parameter int ALARM_SLOTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	atmt_chan_if.sink   req,
	atmt_chan_if.source rsp
);
	import atmt_pkg::*;

	localparam int IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CW = $clog2(ALARM_SLOTS + 1);
	localparam logic [CW-1:0] SLOT_COUNT = CW'(ALARM_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ACT  = 2'd2;

	logic [1:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] cnt_q;
	logic          pend_s1;
	logic [IW-1:0] addr_s1;
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	entry_t        found_data_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          out_valid_q;
	rsp_t          rsp_q;

	req_t          in_req;
	logic          accept;
	logic          needs_scan;
	logic          rd_en;
	logic [4:0]    key_hour;
	logic [5:0]    key_minute;
	logic          key_match;
	logic          rd_valid;
	entry_t        rd_data;
	logic          act_fire;
	rsp_t          act_rsp;
	slot_cmd_t     act_cmd;
	slot_cmd_t     cmd;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	assign in_req    = req.payload;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Decide at acceptance whether the request needs a walk over the slots.
	always_comb begin
		unique case (in_req.op)
			OP_TICK:   needs_scan = (in_req.time_second == SECOND_ZERO);
			OP_ADD:    needs_scan = (in_req.entry_hour < HOUR_LIMIT) &&
				(in_req.entry_minute < MINUTE_LIMIT);
			OP_REMOVE: needs_scan = 1'b1;
			OP_SET_EN: needs_scan = 1'b1;
			OP_QUERY:  needs_scan = 1'b1;
			default:   needs_scan = 1'b0;
		endcase
	end

	// The lookup key is the current time for a tick, the alarm key otherwise.
	assign key_hour   = (req_q.op == OP_TICK) ? req_q.time_hour : req_q.entry_hour;
	assign key_minute = (req_q.op == OP_TICK) ? req_q.time_minute : req_q.entry_minute;

	assign rd_en     = (state_q == ST_SCAN) && (cnt_q < SLOT_COUNT);
	assign key_match = rd_valid && (rd_data.hour == key_hour) && (rd_data.minute == key_minute);

	atmt_slot_store #(
		.SLOTS (ALARM_SLOTS),
		.IW    (IW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (cnt_q[IW-1:0]),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// Work out the response and the table update once the scan is complete or skipped.
	always_comb begin
		act_rsp = '{status: STATUS_REJECT, fired: 1'b0, fired_is_play: 1'b0, is_active: 1'b0};
		act_cmd = '0;
		wr_addr = found_idx_q;
		wr_data = found_data_q;
		unique case (req_q.op)
			OP_TICK: begin
				act_rsp.status        = STATUS_OK;
				act_rsp.fired         = found_q && found_data_q.enabled;
				act_rsp.fired_is_play = found_q && found_data_q.enabled && found_data_q.play;
			end
			OP_ADD: begin
				wr_addr = free_idx_q;
				wr_data = '{hour: req_q.entry_hour, minute: req_q.entry_minute,
					enabled: 1'b1, play: req_q.play_kind};
				if ((req_q.entry_hour < HOUR_LIMIT) && (req_q.entry_minute < MINUTE_LIMIT) &&
					!found_q && free_found_q) begin
					act_rsp.status    = STATUS_OK;
					act_cmd.wr_entry  = 1'b1;
					act_cmd.set_valid = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (found_q) begin
					act_rsp.status    = STATUS_OK;
					act_cmd.clr_valid = 1'b1;
				end
			end
			OP_SET_EN: begin
				wr_data.enabled = req_q.enable_value;
				if (found_q) begin
					act_rsp.status   = STATUS_OK;
					act_cmd.wr_entry = 1'b1;
				end
			end
			OP_QUERY: begin
				if (found_q) begin
					act_rsp.status    = STATUS_OK;
					act_rsp.is_active = found_data_q.enabled;
				end
			end
			OP_CLEAR: begin
				act_rsp.status  = STATUS_OK;
				act_cmd.clr_all = 1'b1;
			end
			default: begin
				act_rsp.status = STATUS_REJECT;
			end
		endcase
	end

	assign act_fire = (state_q == ST_ACT) && (!out_valid_q || rsp.ready);
	assign cmd      = act_fire ? act_cmd : '0;

	// Sequencer: accept, walk the slots, then apply the update and post the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= needs_scan ? ST_SCAN : ST_ACT;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_ACT;
					end
					if (pend_s1 && key_match) begin
						found_q <= 1'b1;
					end
					if (pend_s1 && !rd_valid && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				ST_ACT: begin
					if (act_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request copy, slot address pipeline and scan results.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_req;
		end
		addr_s1 <= cnt_q[IW-1:0];
		if ((state_q == ST_SCAN) && pend_s1 && key_match) begin
			found_idx_q  <= addr_s1;
			found_data_q <= rd_data;
		end
		if ((state_q == ST_SCAN) && pend_s1 && !rd_valid && !free_found_q) begin
			free_idx_q <= addr_s1;
		end
	end

	// Response register: holds the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (act_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (act_fire) begin
			rsp_q <= act_rsp;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = rsp_q;

	// Once the update is applied the sequencer is idle and a response is waiting.
	`ATMT_ASSERT(a_act_posts_rsp, clk, arst_n, act_fire |=> (state_q == ST_IDLE) && out_valid_q, "update applied without posting a response")
	// The slot counter never runs past the table.
	`ATMT_ASSERT(a_cnt_bound, clk, arst_n, (state_q == ST_SCAN) |-> (cnt_q <= SLOT_COUNT), "slot counter beyond table size")
	// A fired alarm is only reported on a successful response.
	`ATMT_ASSERT(a_fire_ok, clk, arst_n, (rsp.valid && (rsp.payload.fired || rsp.payload.fired_is_play)) |-> (rsp.payload.fired && (rsp.payload.status == STATUS_OK)), "inconsistent fired response")
	// Only one request is in progress at a time.
	`ATMT_ASSERT(a_one_req, clk, arst_n, accept |=> !req.ready, "request accepted while another is in progress")

endmodule

`default_nettype wire
